/* design/les_pkg.sv */
// ----------------------------------------------------------------------------
// Lorenz Euler stepper package
// Shared constants, register indexes, the controller state type and the
// command bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package les_pkg;

    localparam int WORD_BITS_DEF = 40;
    localparam int FRAC_BITS_DEF = 24;

    localparam int CFG_BITS       = 40;
    localparam int CFG_INDEX_BITS = 3;
    localparam int TSTEP_BITS     = 25;
    localparam int RLEN_BITS      = 16;
    localparam int POINT_BITS     = 40;
    localparam int STEP_BITS      = 16;

    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 3 * POINT_BITS + STEP_BITS;

    localparam logic signed [CFG_BITS-1:0] SIGMA_RESET = 40'sd167772160;
    localparam logic signed [CFG_BITS-1:0] BETA_RESET  = 40'sd44738124;
    localparam logic signed [CFG_BITS-1:0] RHO_RESET   = 40'sd469762048;
    localparam logic [TSTEP_BITS-1:0]      TSTEP_RESET = 25'd16777;
    localparam logic signed [CFG_BITS-1:0] SCALE_RESET = 40'sd335544;
    localparam logic [RLEN_BITS-1:0]       RLEN_RESET  = 16'd50000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SIGMA        = 3'd0,
        REG_BETA         = 3'd1,
        REG_RHO          = 3'd2,
        REG_TIME_STEP    = 3'd3,
        REG_OUTPUT_SCALE = 3'd4,
        REG_RUN_LENGTH   = 3'd5
    } cfg_reg_t;

    // One entry per multiply of an integration step, in issue order.
    typedef enum logic [3:0] {
        OP_DX = 4'd0,
        OP_DY = 4'd1,
        OP_XY = 4'd2,
        OP_DZ = 4'd3,
        OP_NX = 4'd4,
        OP_NY = 4'd5,
        OP_NZ = 4'd6,
        OP_SX = 4'd7,
        OP_SY = 4'd8,
        OP_SZ = 4'd9
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_WRITE,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic start;
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic write;
        logic finish;
        op_t  op;
    } dp_cmd_t;

endpackage

/* design/les_ctrl.sv */
// ----------------------------------------------------------------------------
// Lorenz Euler stepper controller
// Sequences the multiply operations of one step through the datapath and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module les_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output les_pkg::dp_cmd_t  cmd
);

    les_pkg::ctrl_state_t state_reg;
    les_pkg::ctrl_state_t state_next;
    les_pkg::op_t         op_reg;
    les_pkg::op_t         op_next;
    logic                 valid_reg;
    logic                 valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= les_pkg::ST_IDLE;
            op_reg    <= les_pkg::OP_DX;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        valid_next    = valid_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        cmd.op        = op_reg;

        if (valid_reg && m_axis_tready)
        begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            les_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.start  = 1'b1;
                    op_next    = les_pkg::OP_DX;
                    state_next = les_pkg::ST_LOAD;
                end
            end
            les_pkg::ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = les_pkg::ST_MUL_LO;
            end
            les_pkg::ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = les_pkg::ST_MUL_HI;
            end
            les_pkg::ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = les_pkg::ST_WRITE;
            end
            les_pkg::ST_WRITE:
            begin
                cmd.write = 1'b1;
                if (op_reg == les_pkg::OP_SZ)
                begin
                    state_next = les_pkg::ST_DONE;
                end
                else
                begin
                    op_next    = les_pkg::op_t'(op_reg + 4'd1);
                    state_next = les_pkg::ST_LOAD;
                end
            end
            les_pkg::ST_DONE:
            begin
                if (!valid_reg || m_axis_tready)
                begin
                    cmd.finish = 1'b1;
                    valid_next = 1'b1;
                    state_next = les_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = les_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = valid_reg;

endmodule

/* design/les_datapath.sv */
// ----------------------------------------------------------------------------
// Lorenz Euler stepper datapath
// Configuration registers, the point state, one shared split multiplier
// with saturating post-processing, and the output register.
// ----------------------------------------------------------------------------
module les_datapath #(
    parameter int WORD_BITS = les_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = les_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  les_pkg::dp_cmd_t                      cmd,
    input  logic                                  restart,
    input  logic                                  cfg_we,
    input  logic [les_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [les_pkg::CFG_BITS-1:0]          cfg_data,
    output logic [les_pkg::POINT_BITS-1:0]        point_x,
    output logic [les_pkg::POINT_BITS-1:0]        point_y,
    output logic [les_pkg::POINT_BITS-1:0]        point_z,
    output logic [les_pkg::STEP_BITS-1:0]         step_index,
    output logic                                  run_end,
    output logic                                  saturated
);

    localparam int W      = WORD_BITS;
    localparam int LO     = WORD_BITS / 2;
    localparam int MB     = LO + 1;
    localparam int MP     = WORD_BITS + MB;
    localparam int PW     = 2 * WORD_BITS;
    localparam int EXT_W  = (WORD_BITS > les_pkg::CFG_BITS) ? WORD_BITS : les_pkg::CFG_BITS;
    localparam int OUT_W  = (WORD_BITS > les_pkg::POINT_BITS) ? WORD_BITS : les_pkg::POINT_BITS;
    localparam int RB     = les_pkg::RLEN_BITS;

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE  =
        {{(W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    localparam logic signed [W-1:0] SIGMA_INIT = W'(les_pkg::SIGMA_RESET);
    localparam logic signed [W-1:0] BETA_INIT  = W'(les_pkg::BETA_RESET);
    localparam logic signed [W-1:0] RHO_INIT   = W'(les_pkg::RHO_RESET);
    localparam logic signed [W-1:0] SCALE_INIT = W'(les_pkg::SCALE_RESET);
    localparam logic signed [W-1:0] TSTEP_INIT = W'(les_pkg::TSTEP_RESET);

    // Saturating add or subtract; the top bit of the result is the overflow flag.
    function automatic logic [W:0] add_sat(input logic signed [W-1:0] a,
                                           input logic signed [W-1:0] b,
                                           input logic                sub);
        logic signed [W:0] s;
        s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
        if (s[W] != s[W-1])
        begin
            return {1'b1, (s[W] ? WMIN : WMAX)};
        end
        return {1'b0, s[W-1:0]};
    endfunction

    logic signed [W-1:0]  sigma_reg, beta_reg, rho_reg, tstep_reg, scale_reg;
    logic signed [W-1:0]  sigma_next, beta_next, rho_next, tstep_next, scale_next;
    logic [RB-1:0]        rlen_reg, rlen_next;
    logic signed [W-1:0]  px_reg, py_reg, pz_reg, px_next, py_next, pz_next;
    logic [RB-1:0]        count_reg, count_next;
    logic signed [W-1:0]  dx_reg, dy_reg, dz_reg, tmp_reg;
    logic signed [W-1:0]  dx_next, dy_next, dz_next, tmp_next;
    logic signed [W-1:0]  a_reg, b_reg, a_next, b_next;
    logic signed [MP-1:0] part_reg, part_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic                 sat_reg, sat_next;
    logic [les_pkg::POINT_BITS-1:0] ox_reg, oy_reg, oz_reg, ox_next, oy_next, oz_next;
    logic [RB-1:0]        oidx_reg, oidx_next;
    logic                 oend_reg, oend_next, osat_reg, osat_next;

    logic signed [EXT_W-1:0] cfg_ext;
    logic                    cfg_fits;
    logic signed [W-1:0]     cfg_word;

    logic signed [MB-1:0]    mul_b;
    logic signed [MP-1:0]    mul_p;

    logic [W:0]              ld_res;
    logic                    prod_fits;
    logic signed [W-1:0]     pv;
    logic                    pv_ovf;
    logic signed [W-1:0]     wa, wb;
    logic                    wsub;
    logic [W:0]              wr_res;

    logic [RB-1:0]           run_len;
    logic [RB:0]             idx_inc;
    logic                    is_end;
    logic signed [OUT_W-1:0] ext_x, ext_y, ext_z;

    // Sigma, beta, rho and scale writes: sign-extend the 40-bit value, then clamp to the word.
    assign cfg_ext  = EXT_W'(signed'(cfg_data));
    assign cfg_fits = (cfg_ext[EXT_W-1:W-1] == {(EXT_W-W+1){cfg_ext[EXT_W-1]}});
    assign cfg_word = cfg_fits ? cfg_ext[W-1:0] : (cfg_ext[EXT_W-1] ? WMIN : WMAX);

    // One multiplier: the low half of b (unsigned) first, then the signed high half.
    assign mul_b = cmd.mul_hi ? MB'(signed'(b_reg[W-1:LO])) : MB'(signed'({1'b0, b_reg[LO-1:0]}));
    assign mul_p = MP'(a_reg) * MP'(mul_b);

    assign ld_res = (cmd.op == les_pkg::OP_DX) ? add_sat(py_reg, px_reg, 1'b1)
                                               : add_sat(rho_reg, pz_reg, 1'b1);

    assign prod_fits = (prod_reg[PW-1:FRAC_BITS+W-1] ==
                        {(W-FRAC_BITS+1){prod_reg[PW-1]}});
    assign pv        = prod_fits ? prod_reg[FRAC_BITS+W-1:FRAC_BITS]
                                 : (prod_reg[PW-1] ? WMIN : WMAX);
    assign pv_ovf    = !prod_fits;

    always_comb
    begin
        wa   = px_reg;
        wb   = pv;
        wsub = 1'b0;
        unique case (cmd.op)
            les_pkg::OP_DY:
            begin
                wa   = pv;
                wb   = py_reg;
                wsub = 1'b1;
            end
            les_pkg::OP_DZ:
            begin
                wa   = tmp_reg;
                wb   = pv;
                wsub = 1'b1;
            end
            les_pkg::OP_NY: wa = py_reg;
            les_pkg::OP_NZ: wa = pz_reg;
            default:        wa = px_reg;
        endcase
    end

    assign wr_res = add_sat(wa, wb, wsub);

    assign run_len = (rlen_reg == '0) ? RB'(1) : rlen_reg;
    assign idx_inc = {1'b0, count_reg} + {{RB{1'b0}}, 1'b1};
    assign is_end  = (idx_inc >= {1'b0, run_len});

    assign ext_x = OUT_W'(dx_reg);
    assign ext_y = OUT_W'(dy_reg);
    assign ext_z = OUT_W'(dz_reg);

    always_comb
    begin
        sigma_next = sigma_reg;
        beta_next  = beta_reg;
        rho_next   = rho_reg;
        tstep_next = tstep_reg;
        scale_next = scale_reg;
        rlen_next  = rlen_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pz_next    = pz_reg;
        count_next = count_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dz_next    = dz_reg;
        tmp_next   = tmp_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        part_next  = part_reg;
        prod_next  = prod_reg;
        sat_next   = sat_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oz_next    = oz_reg;
        oidx_next  = oidx_reg;
        oend_next  = oend_reg;
        osat_next  = osat_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                les_pkg::REG_SIGMA:        sigma_next = cfg_word;
                les_pkg::REG_BETA:         beta_next  = cfg_word;
                les_pkg::REG_RHO:          rho_next   = cfg_word;
                les_pkg::REG_TIME_STEP:    tstep_next = W'(cfg_data[les_pkg::TSTEP_BITS-1:0]);
                les_pkg::REG_OUTPUT_SCALE: scale_next = cfg_word;
                les_pkg::REG_RUN_LENGTH:   rlen_next  = cfg_data[RB-1:0];
                default:                   rlen_next  = rlen_reg;
            endcase
        end

        priority if (cmd.start)
        begin
            sat_next = 1'b0;
            if (restart)
            begin
                px_next    = ONE;
                py_next    = ONE;
                pz_next    = ONE;
                count_next = '0;
            end
        end
        else if (cmd.load)
        begin
            unique case (cmd.op)
                les_pkg::OP_DX:
                begin
                    a_next   = sigma_reg;
                    b_next   = ld_res[W-1:0];
                    sat_next = sat_reg | ld_res[W];
                end
                les_pkg::OP_DY:
                begin
                    a_next   = px_reg;
                    b_next   = ld_res[W-1:0];
                    sat_next = sat_reg | ld_res[W];
                end
                les_pkg::OP_XY:
                begin
                    a_next = px_reg;
                    b_next = py_reg;
                end
                les_pkg::OP_DZ:
                begin
                    a_next = beta_reg;
                    b_next = pz_reg;
                end
                les_pkg::OP_NX:
                begin
                    a_next = tstep_reg;
                    b_next = dx_reg;
                end
                les_pkg::OP_NY:
                begin
                    a_next = tstep_reg;
                    b_next = dy_reg;
                end
                les_pkg::OP_NZ:
                begin
                    a_next = tstep_reg;
                    b_next = dz_reg;
                end
                les_pkg::OP_SX:
                begin
                    a_next = px_reg;
                    b_next = scale_reg;
                end
                les_pkg::OP_SY:
                begin
                    a_next = py_reg;
                    b_next = scale_reg;
                end
                les_pkg::OP_SZ:
                begin
                    a_next = pz_reg;
                    b_next = scale_reg;
                end
                default:
                begin
                    a_next = a_reg;
                end
            endcase
        end
        else if (cmd.mul_lo)
        begin
            part_next = mul_p;
        end
        else if (cmd.mul_hi)
        begin
            prod_next = (PW'(mul_p) <<< LO) + PW'(part_reg);
        end
        else if (cmd.write)
        begin
            sat_next = sat_reg | pv_ovf;
            unique case (cmd.op)
                les_pkg::OP_DX: dx_next = pv;
                les_pkg::OP_XY: tmp_next = pv;
                les_pkg::OP_SX: dx_next = pv;
                les_pkg::OP_SY: dy_next = pv;
                les_pkg::OP_SZ: dz_next = pv;
                les_pkg::OP_DY:
                begin
                    dy_next  = wr_res[W-1:0];
                    sat_next = sat_reg | pv_ovf | wr_res[W];
                end
                les_pkg::OP_DZ:
                begin
                    dz_next  = wr_res[W-1:0];
                    sat_next = sat_reg | pv_ovf | wr_res[W];
                end
                les_pkg::OP_NX:
                begin
                    px_next  = wr_res[W-1:0];
                    sat_next = sat_reg | pv_ovf | wr_res[W];
                end
                les_pkg::OP_NY:
                begin
                    py_next  = wr_res[W-1:0];
                    sat_next = sat_reg | pv_ovf | wr_res[W];
                end
                les_pkg::OP_NZ:
                begin
                    pz_next  = wr_res[W-1:0];
                    sat_next = sat_reg | pv_ovf | wr_res[W];
                end
                default:
                begin
                    sat_next = sat_reg;
                end
            endcase
        end
        else if (cmd.finish)
        begin
            ox_next   = ext_x[les_pkg::POINT_BITS-1:0];
            oy_next   = ext_y[les_pkg::POINT_BITS-1:0];
            oz_next   = ext_z[les_pkg::POINT_BITS-1:0];
            oidx_next = count_reg;
            oend_next = is_end;
            osat_next = sat_reg;
            if (is_end)
            begin
                px_next    = ONE;
                py_next    = ONE;
                pz_next    = ONE;
                count_next = '0;
            end
            else
            begin
                count_next = idx_inc[RB-1:0];
            end
        end
        else
        begin
            sat_next = sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= SIGMA_INIT;
            beta_reg  <= BETA_INIT;
            rho_reg   <= RHO_INIT;
            tstep_reg <= TSTEP_INIT;
            scale_reg <= SCALE_INIT;
            rlen_reg  <= les_pkg::RLEN_RESET;
            px_reg    <= ONE;
            py_reg    <= ONE;
            pz_reg    <= ONE;
            count_reg <= '0;
        end
        else
        begin
            sigma_reg <= sigma_next;
            beta_reg  <= beta_next;
            rho_reg   <= rho_next;
            tstep_reg <= tstep_next;
            scale_reg <= scale_next;
            rlen_reg  <= rlen_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            pz_reg    <= pz_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dz_reg   <= dz_next;
        tmp_reg  <= tmp_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        part_reg <= part_next;
        prod_reg <= prod_next;
        sat_reg  <= sat_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oz_reg   <= oz_next;
        oidx_reg <= oidx_next;
        oend_reg <= oend_next;
        osat_reg <= osat_next;
    end

    assign point_x    = ox_reg;
    assign point_y    = oy_reg;
    assign point_z    = oz_reg;
    assign step_index = oidx_reg;
    assign run_end    = oend_reg;
    assign saturated  = osat_reg;

endmodule

/* design/lorenz_euler_stepper.sv */
// ----------------------------------------------------------------------------
// Lorenz Euler stepper
// Advances the Lorenz system by one explicit Euler step per input item and
// emits the scaled new point, its index in the run and status flags.
//
//   Channel   Direction  Carries
//   s_axis    in         tdata[0] restart
//   m_axis    out        tdata point_x, point_y, point_z, step_index;
//                        tlast run_end; tuser saturated
//   cfg       in         write enable, register index, 40-bit write data
//
// Each item is accepted, then ten multiplies run in turn on the single shared
// multiplier, each as operand load, low half, high half, then saturate and
// write back; last, the result is moved to the output register.
// Reset loads the default coefficients and puts the point at (1,1,1), step 0.
// A finished result waits in the output register while the next item is
// accepted and computed; that item is held before its output stage until
// the waiting result is taken.
// ----------------------------------------------------------------------------
module lorenz_euler_stepper #(
    parameter int WORD_BITS = les_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = les_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // restart
    input  logic [les_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // point_x, point_y, point_z, step_index
    output logic [les_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
    output logic                                 m_axis_tlast,
    // saturated
    output logic                                 m_axis_tuser,
    input  logic                                 cfg_we,
    input  logic [les_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [les_pkg::CFG_BITS-1:0]         cfg_data
);

    les_pkg::dp_cmd_t                cmd;
    logic [les_pkg::POINT_BITS-1:0]  point_x;
    logic [les_pkg::POINT_BITS-1:0]  point_y;
    logic [les_pkg::POINT_BITS-1:0]  point_z;
    logic [les_pkg::STEP_BITS-1:0]   step_index;

    les_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    les_datapath #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .restart    (s_axis_tdata[0]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .step_index (step_index),
        .run_end    (m_axis_tlast),
        .saturated  (m_axis_tuser)
    );

    assign m_axis_tdata = {step_index, point_z, point_y, point_x};

endmodule

/* tb/tb_lorenz_euler_stepper.sv */
// ----------------------------------------------------------------------------
// Lorenz Euler stepper testbench
// Drives step items into the stepper and predicts every emitted point with a
// fixed-point Lorenz integrator of its own. A directed part covers reset
// defaults, restarts, zero and short run lengths, a run shortened mid-way,
// coefficient extremes and writes to unused register indexes. Random phases
// then change all registers between drained phases, with random gaps on the
// input side and random back-pressure on the output side, but for one phase.
// ----------------------------------------------------------------------------
module tb_lorenz_euler_stepper;

    import les_pkg::*;

    localparam int          DRAIN_CYCLES = 60;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          PHASES       = 9;
    localparam int          PHASE_ITEMS  = 100;
    localparam logic [2:0]  REG_SPARE_LO = 3'd6;
    localparam logic [2:0]  REG_SPARE_HI = 3'd7;
    localparam longint      W_MAX = (longint'(1) <<< (WORD_BITS_DEF - 1)) - 1;
    localparam longint      W_MIN = -W_MAX - 1;

    typedef struct {
        logic [POINT_BITS-1:0] x;
        logic [POINT_BITS-1:0] y;
        logic [POINT_BITS-1:0] z;
        logic [STEP_BITS-1:0]  idx;
        logic                  last;
        logic                  sat;
    } point_t;

    class lorenz_scoreboard;
        longint      coef_sigma;
        longint      coef_beta;
        longint      coef_rho;
        longint      dt;
        longint      scale;
        int unsigned steps_per_run;
        longint      px;
        longint      py;
        longint      pz;
        int unsigned step_no;
        bit          step_sat;
        point_t      points_due[$];
        int          errors;
        int          ticks;
        int          checked;
        int          run_ends;
        int          sat_points;

        function new();
            coef_sigma    = longint'(SIGMA_RESET);
            coef_beta     = longint'(BETA_RESET);
            coef_rho      = longint'(RHO_RESET);
            dt            = longint'(TSTEP_RESET);
            scale         = longint'(SCALE_RESET);
            steps_per_run = 32'(RLEN_RESET);
            errors        = 0;
            ticks         = 0;
            checked       = 0;
            run_ends      = 0;
            sat_points    = 0;
            start_run();
        endfunction

        function void start_run();
            px      = longint'(1) <<< FRAC_BITS_DEF;
            py      = px;
            pz      = px;
            step_no = 0;
        endfunction

        function longint clamp_w(logic signed [127:0] v);
            if (v > W_MAX)
            begin
                step_sat = 1'b1;
                return W_MAX;
            end
            if (v < W_MIN)
            begin
                step_sat = 1'b1;
                return W_MIN;
            end
            return longint'(v);
        endfunction

        function longint add_sat(longint a, longint b);
            return clamp_w(128'(a) + 128'(b));
        endfunction

        function longint sub_sat(longint a, longint b);
            return clamp_w(128'(a) - 128'(b));
        endfunction

        function longint mul_q(longint a, longint b);
            logic signed [127:0] wide;
            wide = 128'(a);
            wide = wide * 128'(b);
            wide = wide >>> FRAC_BITS_DEF;
            return clamp_w(wide);
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] d);
            case (idx)
                REG_SIGMA:        coef_sigma = longint'(signed'(d));
                REG_BETA:         coef_beta = longint'(signed'(d));
                REG_RHO:          coef_rho = longint'(signed'(d));
                REG_TIME_STEP:    dt = longint'(d[TSTEP_BITS-1:0]);
                REG_OUTPUT_SCALE: scale = longint'(signed'(d));
                REG_RUN_LENGTH:   steps_per_run = 32'(d[RLEN_BITS-1:0]);
                default:          ;
            endcase
        endfunction

        function void note_tick(logic restart);
            longint      dx;
            longint      dy;
            longint      dz;
            longint      nx;
            longint      ny;
            longint      nz;
            longint      sx;
            longint      sy;
            longint      sz;
            int unsigned len;
            point_t      pt;
            step_sat = 1'b0;
            if (restart)
                start_run();
            dx = mul_q(coef_sigma, sub_sat(py, px));
            dy = sub_sat(mul_q(px, sub_sat(coef_rho, pz)), py);
            dz = sub_sat(mul_q(px, py), mul_q(coef_beta, pz));
            nx = add_sat(px, mul_q(dt, dx));
            ny = add_sat(py, mul_q(dt, dy));
            nz = add_sat(pz, mul_q(dt, dz));
            px = nx;
            py = ny;
            pz = nz;
            sx = mul_q(nx, scale);
            sy = mul_q(ny, scale);
            sz = mul_q(nz, scale);
            len     = (steps_per_run == 0) ? 1 : steps_per_run;
            pt.x    = sx[POINT_BITS-1:0];
            pt.y    = sy[POINT_BITS-1:0];
            pt.z    = sz[POINT_BITS-1:0];
            pt.idx  = step_no[STEP_BITS-1:0];
            pt.last = (step_no + 1 >= len);
            pt.sat  = step_sat;
            points_due.push_back(pt);
            ticks++;
            if (pt.last)
                start_run();
            else
                step_no = step_no + 1;
        endfunction

        function void compare(string field, logic [POINT_BITS-1:0] want,
                              logic [POINT_BITS-1:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
            end
        endfunction

        function void check_point(logic [OUT_TDATA_BITS-1:0] d, logic last, logic user);
            point_t want;
            if (points_due.size() == 0)
            begin
                errors++;
                $display("%0t: point emitted with no item pending: expected none, got %h",
                         $time, d);
                return;
            end
            want = points_due.pop_front();
            checked++;
            if (want.last)
                run_ends++;
            if (want.sat)
                sat_points++;
            compare("point_x", want.x, d[POINT_BITS-1:0]);
            compare("point_y", want.y, d[2*POINT_BITS-1:POINT_BITS]);
            compare("point_z", want.z, d[3*POINT_BITS-1:2*POINT_BITS]);
            compare("step_index", 40'(want.idx), 40'(d[OUT_TDATA_BITS-1:3*POINT_BITS]));
            compare("run_end", 40'(want.last), 40'(last));
            compare("saturated", 40'(want.sat), 40'(user));
        endfunction

        function int pending();
            return points_due.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [IN_TDATA_BITS-1:0]      s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [OUT_TDATA_BITS-1:0]     m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          m_axis_tuser;
    logic                          cfg_we;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [CFG_BITS-1:0]           cfg_data;

    lorenz_scoreboard sb;
    bit               idle_on;
    int               cycles;

    lorenz_euler_stepper u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Results are checked before the same edge's input is noted, so a stray
    // point can never be matched against an item accepted at that edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_point(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_tick(s_axis_tdata[0]);
        end
        m_axis_tready <= !idle_on || ($urandom_range(99) >= 8);
    end

    task automatic send_tick(input logic restart);
        logic [IN_TDATA_BITS-2:0] pad;
        pad = (IN_TDATA_BITS-1)'($urandom);
        while (idle_on && $urandom_range(99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pad, restart};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // The first edge lets the monitor note an item accepted at the edge
    // this task was called on.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        sb.set_reg(idx, d);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CFG_BITS-1:0] pick_coef(int unsigned span);
        longint v;
        if ($urandom_range(3) == 0)
            return 40'({$urandom, $urandom});
        v = longint'($urandom_range(0, span << FRAC_BITS_DEF));
        if ($urandom_range(3) == 0)
            v = -v;
        return v[CFG_BITS-1:0];
    endfunction

    initial
    begin
        logic [CFG_BITS-1:0] val;
        int                  phase;
        int                  n;
        sb            = new();
        idle_on       = 1'b1;
        cycles        = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default coefficients straight out of reset, then a restart mid-run.
        repeat (4) send_tick(1'b0);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);

        // A zero run length behaves as one: every step ends its run.
        wait_drain();
        cfg_write(REG_RUN_LENGTH, 40'd0);
        repeat (2) send_tick(1'b0);

        wait_drain();
        cfg_write(REG_RUN_LENGTH, 40'd3);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);

        // Lowering the run length below the steps already taken ends the run.
        wait_drain();
        cfg_write(REG_RUN_LENGTH, 40'd10);
        repeat (4) send_tick(1'b0);
        wait_drain();
        cfg_write(REG_RUN_LENGTH, 40'd2);
        repeat (2) send_tick(1'b0);

        // Coefficient extremes drive the arithmetic into saturation.
        wait_drain();
        cfg_write(REG_SIGMA, 40'h7F_FFFF_FFFF);
        cfg_write(REG_BETA, 40'h80_0000_0000);
        cfg_write(REG_RHO, 40'h7F_FFFF_FFFF);
        cfg_write(REG_TIME_STEP, 40'hFF_FFFF_FFFF);
        cfg_write(REG_OUTPUT_SCALE, 40'h7F_FFFF_FFFF);
        cfg_write(REG_RUN_LENGTH, 40'hFF_FFFF_FFFF);
        repeat (2) send_tick(1'b0);

        wait_drain();
        cfg_write(REG_SIGMA, 40'h80_0000_0000);
        cfg_write(REG_BETA, 40'h7F_FFFF_FFFF);
        cfg_write(REG_RHO, 40'h80_0000_0000);
        cfg_write(REG_TIME_STEP, 40'hFF_FE00_0000);
        cfg_write(REG_OUTPUT_SCALE, 40'h80_0000_0000);
        send_tick(1'b1);
        send_tick(1'b0);

        // Writes to unused indexes must leave every register alone.
        wait_drain();
        cfg_write(REG_SPARE_LO, 40'({$urandom, $urandom}));
        cfg_write(REG_SPARE_HI, 40'({$urandom, $urandom}));
        send_tick(1'b0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drain();
            idle_on = (phase != 4);
            cfg_write(REG_SIGMA, pick_coef(20));
            cfg_write(REG_BETA, pick_coef(5));
            cfg_write(REG_RHO, pick_coef(50));
            cfg_write(REG_OUTPUT_SCALE, pick_coef(2));
            val = 40'({$urandom, $urandom});
            case ($urandom_range(3))
                0: val[TSTEP_BITS-1:0] = TSTEP_BITS'($urandom_range(0, 1 << 18));
                1: ;
                2: val[TSTEP_BITS-1:0] = 25'd1 << FRAC_BITS_DEF;
                default: val[TSTEP_BITS-1:0] =
                    TSTEP_BITS'($urandom_range(0, 1 << FRAC_BITS_DEF));
            endcase
            cfg_write(REG_TIME_STEP, val);
            val = 40'({$urandom, $urandom});
            case ($urandom_range(5))
                0: val[RLEN_BITS-1:0] = '0;
                1: val[RLEN_BITS-1:0] = '1;
                5: ;
                default: val[RLEN_BITS-1:0] = RLEN_BITS'($urandom_range(1, 12));
            endcase
            cfg_write(REG_RUN_LENGTH, val);
            if ($urandom_range(1) == 1)
                cfg_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                          40'({$urandom, $urandom}));
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    wait_drain();
                send_tick($urandom_range(99) < 5);
            end
        end

        wait_drain();
        $display("Stepped %0d items and checked %0d points: %0d run ends, %0d saturated.",
                 sb.ticks, sb.checked, sb.run_ends, sb.sat_points);
        $display("Register settings: reset defaults, directed extremes and %0d random phases.",
                 PHASES);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
